@@ hw/rtl/apsp_pkg.sv @@
// Shared types and constants for the all-pairs shortest path block.
// Used by apsp_ctrl, apsp_dp and all_pairs_shortest_path; depends on nothing else.
`default_nettype none

package apsp_pkg;

	localparam logic [1:0] OP_LOAD = 2'd0;
	localparam logic [1:0] OP_RUN  = 2'd1;
	localparam logic [1:0] OP_READ = 2'd2;

	localparam logic [6:0] NUM_NODES_RESET = 7'd64;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [5:0]  row;
		logic [5:0]  col;
		logic [15:0] weight;
	} apsp_cmd_t;

	typedef struct packed {
		logic [15:0] distance;
		logic [5:0]  next_hop;
		logic        has_next;
		logic        run_done;
	} apsp_rsp_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_READ,
		ST_START,
		ST_INIT_RD,
		ST_INIT_WR,
		ST_ROW_RD,
		ST_ROW_LAT,
		ST_REL_RD,
		ST_REL_WR,
		ST_FIN
	} apsp_state_t;

	typedef enum logic [3:0] {
		DP_NONE,
		DP_LOAD,
		DP_READ_ISSUE,
		DP_READ_OUT,
		DP_RUN_START,
		DP_INIT_RD,
		DP_INIT_WR,
		DP_ROW_RD,
		DP_ROW_LAT,
		DP_REL_RD,
		DP_REL_WR,
		DP_RUN_OUT
	} apsp_dp_op_t;

	typedef struct packed {
		logic out_free;
		logic n_zero;
		logic w_last;
		logic v_last;
		logic k_last;
	} apsp_status_t;

endpackage

`default_nettype wire

@@ hw/rtl/apsp_ctrl.sv @@
// Sequencing state machine for the all-pairs shortest path block.
// Uses apsp_pkg; drives the datapath apsp_dp by one operation code per cycle.
`default_nettype none

module apsp_ctrl (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   cmd_valid,
	output logic                  cmd_ready,
	input  wire [1:0]             opcode,
	input  apsp_pkg::apsp_status_t status,
	output apsp_pkg::apsp_dp_op_t  dp_op
);

	apsp_pkg::apsp_state_t state_q, state_next;
	logic                  take;
	logic                  needs_out;

	// Reads and runs each produce a beat, so they wait for room at the output.
	assign needs_out = (opcode == apsp_pkg::OP_READ) || (opcode == apsp_pkg::OP_RUN);
	assign take      = cmd_valid && cmd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= apsp_pkg::ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		case (state_q)
			apsp_pkg::ST_IDLE: begin
				if (take && opcode == apsp_pkg::OP_READ) begin
					state_next = apsp_pkg::ST_READ;
				end else if (take && opcode == apsp_pkg::OP_RUN) begin
					state_next = apsp_pkg::ST_START;
				end
			end
			apsp_pkg::ST_READ:    state_next = apsp_pkg::ST_IDLE;
			apsp_pkg::ST_START: begin
				state_next = status.n_zero ? apsp_pkg::ST_FIN : apsp_pkg::ST_INIT_RD;
			end
			apsp_pkg::ST_INIT_RD: state_next = apsp_pkg::ST_INIT_WR;
			apsp_pkg::ST_INIT_WR: begin
				if (status.w_last && status.v_last) begin
					state_next = apsp_pkg::ST_ROW_RD;
				end else begin
					state_next = apsp_pkg::ST_INIT_RD;
				end
			end
			apsp_pkg::ST_ROW_RD:  state_next = apsp_pkg::ST_ROW_LAT;
			apsp_pkg::ST_ROW_LAT: state_next = apsp_pkg::ST_REL_RD;
			apsp_pkg::ST_REL_RD:  state_next = apsp_pkg::ST_REL_WR;
			apsp_pkg::ST_REL_WR: begin
				if (!status.w_last) begin
					state_next = apsp_pkg::ST_REL_RD;
				end else if (status.v_last && status.k_last) begin
					state_next = apsp_pkg::ST_FIN;
				end else begin
					state_next = apsp_pkg::ST_ROW_RD;
				end
			end
			apsp_pkg::ST_FIN: begin
				if (status.out_free) begin
					state_next = apsp_pkg::ST_IDLE;
				end
			end
			default: state_next = apsp_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd_ready = 1'b0;
		dp_op     = apsp_pkg::DP_NONE;
		case (state_q)
			apsp_pkg::ST_IDLE: begin
				cmd_ready = !needs_out || status.out_free;
				if (take) begin
					case (opcode)
						apsp_pkg::OP_LOAD: dp_op = apsp_pkg::DP_LOAD;
						apsp_pkg::OP_READ: dp_op = apsp_pkg::DP_READ_ISSUE;
						apsp_pkg::OP_RUN:  dp_op = apsp_pkg::DP_RUN_START;
						default:           dp_op = apsp_pkg::DP_NONE;
					endcase
				end
			end
			apsp_pkg::ST_READ:    dp_op = apsp_pkg::DP_READ_OUT;
			apsp_pkg::ST_START:   dp_op = apsp_pkg::DP_NONE;
			apsp_pkg::ST_INIT_RD: dp_op = apsp_pkg::DP_INIT_RD;
			apsp_pkg::ST_INIT_WR: dp_op = apsp_pkg::DP_INIT_WR;
			apsp_pkg::ST_ROW_RD:  dp_op = apsp_pkg::DP_ROW_RD;
			apsp_pkg::ST_ROW_LAT: dp_op = apsp_pkg::DP_ROW_LAT;
			apsp_pkg::ST_REL_RD:  dp_op = apsp_pkg::DP_REL_RD;
			apsp_pkg::ST_REL_WR:  dp_op = apsp_pkg::DP_REL_WR;
			apsp_pkg::ST_FIN: begin
				if (status.out_free) begin
					dp_op = apsp_pkg::DP_RUN_OUT;
				end
			end
			default: dp_op = apsp_pkg::DP_NONE;
		endcase
	end

endmodule

`default_nettype wire

@@ hw/rtl/apsp_dp.sv @@
// Datapath of the all-pairs shortest path block: distance and next-hop memories,
// loop counters, relaxation add and compare, output register. Uses apsp_pkg.
`default_nettype none

module apsp_dp #(
	parameter int MAX_NODES   = 64,
	parameter int WEIGHT_BITS = 16
) (
	input  wire                    clk,
	input  wire                    arst_n,
	input  apsp_pkg::apsp_dp_op_t  dp_op,
	input  apsp_pkg::apsp_cmd_t    cmd,
	input  wire                    cfg_we,
	input  wire [6:0]              cfg_wdata,
	output apsp_pkg::apsp_status_t status,
	output logic                   rsp_valid,
	input  wire                    rsp_ready,
	output apsp_pkg::apsp_rsp_t    rsp
);

	localparam int VW    = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
	localparam int NW    = $clog2(MAX_NODES + 1);
	localparam int AW    = 2 * VW;
	localparam int DEPTH = 1 << AW;
	localparam int HW    = VW + 1;
	localparam logic [WEIGHT_BITS-1:0] INF = {WEIGHT_BITS{1'b1}};

	logic [WEIGHT_BITS-1:0] dist_mem [DEPTH];
	logic [HW-1:0]          hop_mem  [DEPTH];

	logic [6:0]             num_nodes_q;
	logic [NW-1:0]          n_q;
	logic [NW-1:0]          n_m1;
	logic [VW-1:0]          k_q, v_q, w_q;
	logic [WEIGHT_BITS-1:0] dist_a_q, dist_b_q, dvk_q;
	logic [HW-1:0]          hop_rd_q, hvk_q;
	logic                   rd_inside_q;
	logic                   rsp_valid_q;
	apsp_pkg::apsp_rsp_t    rsp_q;

	logic [VW-1:0]          row_v, col_v;
	logic                   in_range;
	logic [AW-1:0]          addr_a, addr_b, addr_h, addr_w;
	logic                   dist_we, hop_we;
	logic [WEIGHT_BITS-1:0] dist_wd;
	logic [HW-1:0]          hop_wd;
	logic [WEIGHT_BITS:0]   cand;
	logic                   improve;
	logic                   diag;
	logic                   advance;

	assign row_v    = VW'(cmd.row);
	assign col_v    = VW'(cmd.col);
	assign in_range = (32'(cmd.row) < 32'(MAX_NODES)) && (32'(cmd.col) < 32'(MAX_NODES));

	assign n_m1 = n_q - NW'(1);
	assign status.out_free = !rsp_valid_q || rsp_ready;
	assign status.n_zero   = (n_q == '0);
	assign status.w_last   = (NW'(w_q) == n_m1);
	assign status.v_last   = (NW'(v_q) == n_m1);
	assign status.k_last   = (NW'(k_q) == n_m1);

	// Port A serves d[k][w] during relaxation, port B always d[v][w].
	always_comb begin
		case (dp_op)
			apsp_pkg::DP_READ_ISSUE: addr_a = {row_v, col_v};
			apsp_pkg::DP_ROW_RD:     addr_a = {v_q, k_q};
			apsp_pkg::DP_REL_RD:     addr_a = {k_q, w_q};
			default:                 addr_a = {v_q, w_q};
		endcase
		addr_b = {v_q, w_q};
		addr_h = (dp_op == apsp_pkg::DP_ROW_RD) ? {v_q, k_q} : {row_v, col_v};
		addr_w = (dp_op == apsp_pkg::DP_LOAD) ? {row_v, col_v} : {v_q, w_q};
	end

	// The column k and row k do not change during pass k, so d[v][k] is held per row.
	assign cand    = {1'b0, dvk_q} + {1'b0, dist_a_q};
	assign improve = (cand < {1'b0, INF}) && ({1'b0, dist_b_q} > cand);
	assign diag    = (v_q == w_q);

	always_comb begin
		dist_we = 1'b0;
		hop_we  = 1'b0;
		dist_wd = WEIGHT_BITS'(cmd.weight);
		hop_wd  = '0;
		case (dp_op)
			apsp_pkg::DP_LOAD: begin
				dist_we = in_range;
			end
			apsp_pkg::DP_INIT_WR: begin
				dist_we = diag;
				dist_wd = '0;
				hop_we  = 1'b1;
				hop_wd  = (!diag && dist_a_q != INF) ? {1'b1, w_q} : '0;
			end
			apsp_pkg::DP_REL_WR: begin
				dist_we = improve;
				dist_wd = cand[WEIGHT_BITS-1:0];
				hop_we  = improve;
				hop_wd  = hvk_q;
			end
			default: begin
				dist_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (dist_we) begin
			dist_mem[addr_w] <= dist_wd;
		end
		dist_a_q <= dist_mem[addr_a];
		dist_b_q <= dist_mem[addr_b];
	end

	always_ff @(posedge clk) begin
		if (hop_we) begin
			hop_mem[addr_w] <= hop_wd;
		end
		hop_rd_q <= hop_mem[addr_h];
	end

	always_ff @(posedge clk) begin
		if (dp_op == apsp_pkg::DP_ROW_LAT) begin
			dvk_q <= dist_a_q;
			hvk_q <= hop_rd_q;
		end
		if (dp_op == apsp_pkg::DP_READ_ISSUE) begin
			rd_inside_q <= in_range;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_nodes_q <= apsp_pkg::NUM_NODES_RESET;
		end else if (cfg_we) begin
			num_nodes_q <= cfg_wdata;
		end
	end

	assign advance = (dp_op == apsp_pkg::DP_INIT_WR) || (dp_op == apsp_pkg::DP_REL_WR);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q <= '0;
			k_q <= '0;
			v_q <= '0;
			w_q <= '0;
		end else if (dp_op == apsp_pkg::DP_RUN_START) begin
			n_q <= (32'(num_nodes_q) > 32'(MAX_NODES)) ? NW'(MAX_NODES) : NW'(num_nodes_q);
			k_q <= '0;
			v_q <= '0;
			w_q <= '0;
		end else if (advance) begin
			if (!status.w_last) begin
				w_q <= w_q + VW'(1);
			end else begin
				w_q <= '0;
				if (!status.v_last) begin
					v_q <= v_q + VW'(1);
				end else begin
					v_q <= '0;
					if (dp_op == apsp_pkg::DP_REL_WR) begin
						k_q <= status.k_last ? '0 : k_q + VW'(1);
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (dp_op == apsp_pkg::DP_READ_OUT || dp_op == apsp_pkg::DP_RUN_OUT) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (dp_op == apsp_pkg::DP_READ_OUT) begin
			rsp_q.run_done <= 1'b0;
			if (rd_inside_q) begin
				rsp_q.distance <= 16'(dist_a_q);
				rsp_q.has_next <= hop_rd_q[HW-1];
				rsp_q.next_hop <= hop_rd_q[HW-1] ? 6'(hop_rd_q[VW-1:0]) : 6'd0;
			end else begin
				rsp_q.distance <= 16'(INF);
				rsp_q.has_next <= 1'b0;
				rsp_q.next_hop <= 6'd0;
			end
		end else if (dp_op == apsp_pkg::DP_RUN_OUT) begin
			rsp_q.distance <= 16'd0;
			rsp_q.next_hop <= 6'd0;
			rsp_q.has_next <= 1'b0;
			rsp_q.run_done <= 1'b1;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

`default_nettype wire

@@ hw/rtl/all_pairs_shortest_path.sv @@
// Top level of the all-pairs shortest path block: controller plus datapath.
// Uses apsp_pkg, apsp_ctrl and apsp_dp.
//
// A load beat writes one edge weight, if its row and column are in range, and
// gives no result. A read beat's answer passes through the memory read registers
// and then the output register. A run beat recomputes the whole matrix in place for
// n vertices (n = num_nodes, capped at MAX_NODES) and answers with a run_done
// beat: every entry update is a read then a write on the single write port of
// the distance memory, with a read and a latch step per row to fetch d[v][k]. No
// further beat is taken while a run is in progress. Reads and runs wait for the
// output register to have room; loads never do.
`default_nettype none

module all_pairs_shortest_path #(
	parameter int MAX_NODES   = 64,
	parameter int WEIGHT_BITS = 16
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 cmd_valid,
	output logic                cmd_ready,
	input  apsp_pkg::apsp_cmd_t cmd,
	output logic                rsp_valid,
	input  wire                 rsp_ready,
	output apsp_pkg::apsp_rsp_t rsp,
	input  wire                 cfg_we,
	input  wire [6:0]           cfg_wdata
);

	apsp_pkg::apsp_dp_op_t  dp_op;
	apsp_pkg::apsp_status_t status;

	apsp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.opcode    (cmd.opcode),
		.status    (status),
		.dp_op     (dp_op)
	);

	apsp_dp #(
		.MAX_NODES   (MAX_NODES),
		.WEIGHT_BITS (WEIGHT_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.dp_op     (dp_op),
		.cmd       (cmd),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.status    (status),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

endmodule

`default_nettype wire
